>>> src/fwa_pkg.sv
package fwa_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int WINDOW_MAX  = 16;
    localparam int CFG_W       = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int RADIX_BITS = 4;
    localparam int DIV_STEPS  = (SUM_W + RADIX_BITS - 1) / RADIX_BITS;
    localparam int DIV_W      = DIV_STEPS * RADIX_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic                          last;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_item;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                          done;
        logic signed [SAMPLE_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

>>> src/fwa_front.sv
module fwa_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fwa_pkg::t_item i_item,
    output logic           o_valid,
    output fwa_pkg::t_item o_item,
    input  logic           i_pop
);
    import fwa_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/fwa_div.sv
module fwa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fwa_pkg::t_div_req i_req,
    output fwa_pkg::t_div_rsp o_rsp
);
    import fwa_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [STEP_W-1:0] r_steps;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_quo;
    logic [CNT_W-1:0]  n_rem;
    logic [DIV_W-1:0]  n_quo;
    logic [SUM_W-1:0]  w_mag;
    logic [DIV_W-1:0]  w_signed_quo;

    assign w_mag = i_req.dividend[SUM_W-1] ? (~i_req.dividend + SUM_W'(1))
                                           : i_req.dividend;

    // four restoring steps per cycle on a narrow remainder
    always_comb begin
        logic [CNT_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < RADIX_BITS; k++) begin
            trial = {n_rem, n_quo[DIV_W-1]};
            if (trial >= {1'b0, r_div}) begin
                n_rem = CNT_W'(trial - {1'b0, r_div});
                n_quo = {n_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[CNT_W-1:0];
                n_quo = {n_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign w_signed_quo   = r_neg ? (~r_quo + DIV_W'(1)) : r_quo;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = w_signed_quo[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[SUM_W-1];
            r_quo <= DIV_W'(w_mag);
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= '0;
            end else if (r_busy) begin
                r_steps <= r_steps + STEP_W'(1);
                if (r_steps == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> src/fwa_back.sv
module fwa_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_item_valid,
    input  fwa_pkg::t_item                         i_item,
    output logic                                   o_item_pop,
    input  logic [fwa_pkg::CNT_W-1:0]              i_win,
    output fwa_pkg::t_div_req                      o_div_req,
    input  fwa_pkg::t_div_rsp                      i_div_rsp,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [fwa_pkg::SAMPLE_BITS-1:0] o_out_data,
    output logic                                   o_out_last
);
    import fwa_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]                    r_state;
    logic signed [SAMPLE_BITS-1:0] r_store [WINDOW_MAX];
    logic [CNT_W-1:0]              r_fill;
    logic [IDX_W-1:0]              r_idx;
    logic [CNT_W-1:0]              r_cnt;
    logic signed [SUM_W-1:0]       r_acc;
    logic                          r_last;
    logic                          r_div_start;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;
    logic                          r_out_last;
    logic                          w_load;
    logic                          w_store_pop;

    assign o_item_pop  = (r_state == ST_IDLE) && i_item_valid;
    assign w_load      = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    assign w_store_pop = w_load;

    assign o_div_req.start    = r_div_start;
    assign o_div_req.dividend = r_acc;
    assign o_div_req.divisor  = r_cnt;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_store[r_fill[IDX_W-1:0]] <= i_item.sample;
        end else if (w_store_pop) begin
            for (int i = 0; i < WINDOW_MAX - 1; i++) begin
                r_store[i] <= r_store[i+1];
            end
        end
        if (w_load) begin
            r_out_data <= i_div_rsp.quotient;
            r_out_last <= r_last && (r_fill == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_last      <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_fill  <= r_fill + CNT_W'(1);
                        r_last  <= i_item.last;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_idx <= '0;
                    r_acc <= '0;
                    if (r_last) begin
                        if (r_fill == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cnt   <= (r_fill < i_win) ? r_fill : i_win;
                            r_state <= ST_SUM;
                        end
                    end else if (r_fill >= i_win) begin
                        r_cnt   <= i_win;
                        r_state <= ST_SUM;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SUM: begin
                    r_acc <= r_acc + SUM_W'(r_store[r_idx]);
                    r_idx <= r_idx + IDX_W'(1);
                    if (CNT_W'(r_idx) + CNT_W'(1) == r_cnt) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (i_div_rsp.done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_fill      <= r_fill - CNT_W'(1);
                        r_state     <= ST_CHECK;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_room_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop |-> (r_fill < CNT_W'(WINDOW_MAX)))
        else $error("window full when a sample is taken");

    a_sum_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |-> ((CNT_W'(r_idx) < r_cnt) && (r_cnt != '0)))
        else $error("sum index beyond count");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_last && (r_fill == CNT_W'(1))) |=> (r_fill == '0))
        else $error("record end left samples pending");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

endmodule

>>> src/forward_window_average_unit.sv
// Forward moving average over a record of signed Q16.16 samples.
// Input stream (s_axis_*): one sample per transaction, tlast on the record's
// final sample. Output stream (m_axis_*): one average per window position,
// truncated toward zero; tlast on the record's final average.
// Result i leaves once sample i+W-1 is in; the final sample flushes every
// pending position, each averaged over the samples that remain.
// Window length is set through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while idle, which the block itself does not enforce;
// 0 acts as 1 and values above 16 act as 16.
// Back end flow: a sample that produces no result only passes the idle and
// check states. Each result sums the window from the sample store, runs
// the radix-16 divider (start, 9 steps over a 36-bit sum, done), then
// checks and loads the output register.
// A four-entry input queue keeps accepting while the back end works.
// Reset (synchronous, active low) empties the queue and the window and sets
// the window length to 4. When the receiver stalls the output register holds
// its transaction, the back end halts, and the queue fills then deasserts
// s_axis_tready.
module forward_window_average_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [fwa_pkg::SAMPLE_BITS-1:0]       s_axis_tdata,  // [31:0] sample
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [fwa_pkg::SAMPLE_BITS-1:0]       m_axis_tdata,  // [31:0] average
    output logic                                  m_axis_tlast,
    input  logic                                  i_cfg_wr_en,
    input  logic [fwa_pkg::CFG_W-1:0]             i_cfg_wr_data
);
    import fwa_pkg::*;

    logic [CFG_W-1:0]              r_win_len;
    logic [CNT_W-1:0]              w_win;
    t_item                         w_in_item;
    t_item                         w_q_item;
    logic                          w_q_valid;
    logic                          w_q_pop;
    t_div_req                      w_div_req;
    t_div_rsp                      w_div_rsp;
    logic signed [SAMPLE_BITS-1:0] w_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_win_len <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_win_len == '0) begin
            w_win = CNT_W'(1);
        end else if (32'(r_win_len) > WINDOW_MAX) begin
            w_win = CNT_W'(WINDOW_MAX);
        end else begin
            w_win = CNT_W'(r_win_len);
        end
    end

    assign w_in_item.sample = s_axis_tdata;
    assign w_in_item.last   = s_axis_tlast;

    fwa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    fwa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    fwa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .i_item       (w_q_item),
        .o_item_pop   (w_q_pop),
        .i_win        (w_win),
        .o_div_req    (w_div_req),
        .i_div_rsp    (w_div_rsp),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (w_out_data),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = w_out_data;

endmodule
